// ----- design/messagepack_token_parser_macros.svh -----
// assertion helpers shared by the parser files
`ifndef MESSAGEPACK_TOKEN_PARSER_MACROS_SVH
`define MESSAGEPACK_TOKEN_PARSER_MACROS_SVH

// same-cycle implication, checked out of reset
`define MPK_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MPK_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/mpk_pkg.sv -----
// ----------------------------------------------------------------------------
// mpk_pkg
// Types, tag constants and tag decode functions for the token parser.
// ----------------------------------------------------------------------------
package mpk_pkg;

    typedef enum logic [1:0] {
        PH_TAG  = 2'd0,
        PH_HEAD = 2'd1,
        PH_PAY  = 2'd2,
        PH_SKIP = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        K_UINT = 4'd0,
        K_SINT = 4'd1,
        K_BOOL = 4'd2,
        K_F64  = 4'd3,
        K_F32  = 4'd4,
        K_STR  = 4'd5,
        K_BIN  = 4'd6,
        K_ARR  = 4'd7,
        K_MAP  = 4'd8,
        K_BYTE = 4'd9
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_UNSUP = 2'd1,
        ERR_TRUNC = 2'd2
    } t_err;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] value;
        t_err        err;
        logic        done;
    } t_result;

    localparam logic [7:0] TAG_POS_MAX = 8'h7f;
    localparam logic [7:0] TAG_NEG_MIN = 8'he0;
    localparam logic [7:0] TAG_NIL     = 8'hc0;
    localparam logic [7:0] TAG_FALSE   = 8'hc2;
    localparam logic [7:0] TAG_TRUE    = 8'hc3;
    localparam logic [7:0] TAG_BIN8    = 8'hc4;
    localparam logic [7:0] TAG_BIN32   = 8'hc6;
    localparam logic [7:0] TAG_F32     = 8'hca;
    localparam logic [7:0] TAG_F64     = 8'hcb;
    localparam logic [7:0] TAG_UINT8   = 8'hcc;
    localparam logic [7:0] TAG_UINT64  = 8'hcf;
    localparam logic [7:0] TAG_INT8    = 8'hd0;
    localparam logic [7:0] TAG_INT64   = 8'hd3;
    localparam logic [7:0] TAG_STR8    = 8'hd9;
    localparam logic [7:0] TAG_STR32   = 8'hdb;
    localparam logic [7:0] TAG_ARR16   = 8'hdc;
    localparam logic [7:0] TAG_ARR32   = 8'hdd;
    localparam logic [7:0] TAG_MAP16   = 8'hde;
    localparam logic [7:0] TAG_MAP32   = 8'hdf;

    // header bytes following a tag, zero when none or unsupported
    function automatic logic [3:0] header_size(input logic [7:0] t);
        logic [3:0] hs;
        hs = 4'd0;
        if (t >= TAG_UINT8 && t <= TAG_INT64) begin
            hs = 4'd1 << t[1:0];
        end else if (t == TAG_F32) begin
            hs = 4'd4;
        end else if (t == TAG_F64) begin
            hs = 4'd8;
        end else if (t >= TAG_STR8 && t <= TAG_STR32) begin
            hs = 4'd1 << 2'(t - TAG_STR8);
        end else if (t >= TAG_BIN8 && t <= TAG_BIN32) begin
            hs = 4'd1 << 2'(t - TAG_BIN8);
        end else if (t == TAG_ARR16 || t == TAG_MAP16) begin
            hs = 4'd2;
        end else if (t == TAG_ARR32 || t == TAG_MAP32) begin
            hs = 4'd4;
        end
        return hs;
    endfunction

    function automatic t_kind header_kind(input logic [7:0] t);
        t_kind k;
        k = K_MAP;
        if (t >= TAG_UINT8 && t <= TAG_UINT64) begin
            k = K_UINT;
        end else if (t >= TAG_INT8 && t <= TAG_INT64) begin
            k = K_SINT;
        end else if (t == TAG_F32) begin
            k = K_F32;
        end else if (t == TAG_F64) begin
            k = K_F64;
        end else if (t >= TAG_STR8 && t <= TAG_STR32) begin
            k = K_STR;
        end else if (t >= TAG_BIN8 && t <= TAG_BIN32) begin
            k = K_BIN;
        end else if (t == TAG_ARR16 || t == TAG_ARR32) begin
            k = K_ARR;
        end
        return k;
    endfunction

endpackage

// ----- design/mpk_parse_core.sv -----
// ----------------------------------------------------------------------------
// mpk_parse_core
// Parser state and per-byte decode: turns one byte into zero or one token.
// ----------------------------------------------------------------------------
`include "messagepack_token_parser_macros.svh"

module mpk_parse_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_eom,
    output logic             o_res_valid,
    output mpk_pkg::t_result o_res
);
    import mpk_pkg::*;

    t_phase      r_phase,    n_phase;
    logic [7:0]  r_tag,      n_tag;
    logic [3:0]  r_hdr_left, n_hdr_left;
    logic [63:0] r_acc,      n_acc;
    logic [31:0] r_pay_left, n_pay_left;

    logic [63:0] w_shift;
    logic [63:0] w_val;
    logic [3:0]  w_hs;
    logic [3:0]  w_held_hs;
    t_kind       w_held_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TAG;
            r_tag      <= '0;
            r_hdr_left <= '0;
            r_acc      <= '0;
            r_pay_left <= '0;
        end else if (i_valid) begin
            r_phase    <= n_phase;
            r_tag      <= n_tag;
            r_hdr_left <= n_hdr_left;
            r_acc      <= n_acc;
            r_pay_left <= n_pay_left;
        end
    end

    assign w_shift     = {r_acc[55:0], i_byte};
    assign w_hs        = header_size(i_byte);
    assign w_held_hs   = header_size(r_tag);
    assign w_held_kind = header_kind(r_tag);

    // sign extension of short signed integers
    always_comb begin
        w_val = w_shift;
        if (w_held_kind == K_SINT) begin
            case (w_held_hs)
                4'd1:    if (w_shift[7])  w_val[63:8]  = '1;
                4'd2:    if (w_shift[15]) w_val[63:16] = '1;
                4'd4:    if (w_shift[31]) w_val[63:32] = '1;
                default: w_val = w_shift;
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_tag       = r_tag;
        n_hdr_left  = r_hdr_left;
        n_acc       = r_acc;
        n_pay_left  = r_pay_left;
        o_res_valid = 1'b0;
        o_res.kind  = K_UINT;
        o_res.value = '0;
        o_res.err   = ERR_NONE;
        o_res.done  = i_eom;
        case (r_phase)
            PH_TAG: begin
                o_res_valid = 1'b1;
                if (i_byte <= TAG_POS_MAX) begin
                    o_res.value = {56'd0, i_byte};
                end else if (i_byte >= TAG_NEG_MIN) begin
                    o_res.kind  = K_SINT;
                    o_res.value = {{56{1'b1}}, i_byte};
                end else if (i_byte[7:4] == 4'h8) begin
                    o_res.kind  = K_MAP;
                    o_res.value = {60'd0, i_byte[3:0]};
                end else if (i_byte[7:4] == 4'h9) begin
                    o_res.kind  = K_ARR;
                    o_res.value = {60'd0, i_byte[3:0]};
                end else if (i_byte[7:5] == 3'b101) begin
                    // fixstr
                    if (i_byte[4:0] != 5'd0 && i_eom) begin
                        o_res.err = ERR_TRUNC;
                    end else begin
                        o_res.kind  = K_STR;
                        o_res.value = {59'd0, i_byte[4:0]};
                        if (i_byte[4:0] != 5'd0) begin
                            n_pay_left = {27'd0, i_byte[4:0]};
                            n_phase    = PH_PAY;
                        end
                    end
                end else if (i_byte == TAG_NIL || i_byte == TAG_FALSE) begin
                    o_res.kind = K_BOOL;
                end else if (i_byte == TAG_TRUE) begin
                    o_res.kind  = K_BOOL;
                    o_res.value = 64'd1;
                end else if (w_hs == 4'd0) begin
                    o_res.err   = ERR_UNSUP;
                    o_res.value = {56'd0, i_byte};
                    n_phase     = i_eom ? PH_TAG : PH_SKIP;
                end else if (i_eom) begin
                    o_res.err = ERR_TRUNC;
                end else begin
                    o_res_valid = 1'b0;
                    n_tag       = i_byte;
                    n_hdr_left  = w_hs;
                    n_acc       = '0;
                    n_phase     = PH_HEAD;
                end
            end
            PH_HEAD: begin
                n_acc = w_shift;
                if (r_hdr_left > 4'd1) begin
                    n_hdr_left = r_hdr_left - 4'd1;
                    if (i_eom) begin
                        n_phase     = PH_TAG;
                        n_hdr_left  = '0;
                        o_res_valid = 1'b1;
                        o_res.err   = ERR_TRUNC;
                    end
                end else begin
                    n_hdr_left  = '0;
                    n_phase     = PH_TAG;
                    o_res_valid = 1'b1;
                    if ((w_held_kind == K_STR || w_held_kind == K_BIN) && w_val != '0 && i_eom)
                    begin
                        o_res.err = ERR_TRUNC;
                    end else begin
                        o_res.kind  = w_held_kind;
                        o_res.value = w_val;
                        if ((w_held_kind == K_STR || w_held_kind == K_BIN) && w_val != '0)
                        begin
                            n_pay_left = w_val[31:0];
                            n_phase    = PH_PAY;
                        end
                    end
                end
            end
            PH_PAY: begin
                o_res_valid = 1'b1;
                if (r_pay_left > 32'd1) begin
                    n_pay_left = r_pay_left - 32'd1;
                    if (i_eom) begin
                        n_phase    = PH_TAG;
                        n_pay_left = '0;
                        o_res.err  = ERR_TRUNC;
                    end else begin
                        o_res.kind  = K_BYTE;
                        o_res.value = {56'd0, i_byte};
                    end
                end else begin
                    n_pay_left  = '0;
                    n_phase     = PH_TAG;
                    o_res.kind  = K_BYTE;
                    o_res.value = {56'd0, i_byte};
                end
            end
            PH_SKIP: begin
                // drop bytes until the message ends
                if (i_eom) n_phase = PH_TAG;
            end
            default: begin
                n_phase = PH_TAG;
            end
        endcase
    end

    `MPK_ASSERT_IMP(a_head_count, i_clk, i_rst_n, r_phase == PH_HEAD, r_hdr_left != 4'd0 && r_hdr_left <= 4'd8, "header count out of range in header phase")
    `MPK_ASSERT_IMP(a_head_idle, i_clk, i_rst_n, r_phase != PH_HEAD, r_hdr_left == 4'd0, "stale header count")
    `MPK_ASSERT_IMP(a_pay_count, i_clk, i_rst_n, r_phase == PH_PAY, r_pay_left != 32'd0, "payload phase with no bytes due")
    `MPK_ASSERT_NXT(a_eom_resets, i_clk, i_rst_n, i_valid && i_eom, r_phase == PH_TAG, "parser not back at tag after end of message")

endmodule

// ----- design/mpk_out_reg.sv -----
// ----------------------------------------------------------------------------
// mpk_out_reg
// Result register holding one token until the downstream side takes it.
// ----------------------------------------------------------------------------
`include "messagepack_token_parser_macros.svh"

module mpk_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  mpk_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_valid,
    output mpk_pkg::t_result o_res
);
    import mpk_pkg::*;

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    `MPK_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, i_load, !r_valid || i_ready, "result overwritten before it was taken")
    `MPK_ASSERT_IMP(a_trunc_done, i_clk, i_rst_n, r_valid && r_res.err == ERR_TRUNC, r_res.done, "truncation reported before end of message")

endmodule

// ----- design/messagepack_token_parser.sv -----
// ----------------------------------------------------------------------------
// messagepack_token_parser
// Splits a MessagePack byte stream into tokens: one per scalar or header, one per payload byte.
// ----------------------------------------------------------------------------
//  channel   dir  tdata            tuser                  tlast
//  s_axis    in   [7:0] in_byte    -                      end_of_message
//  m_axis    out  [63:0] value     [3:0] kind [5:4] error message_done
//
//  one byte per cycle sustained while the output is not stalled; a token's byte
//  passes through the input register, then the result register
//  synchronous active-low reset returns the parser to expecting a tag
//  a stalled output holds the result register while the input register
//  still takes one more byte
// ----------------------------------------------------------------------------
module messagepack_token_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [63:0] token_value
    output logic [5:0]  o_m_axis_tuser,   // [3:0] token_kind, [5:4] error_code
    output logic        o_m_axis_tlast
);
    import mpk_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eom;

    logic       w_accept;
    logic       w_advance;
    logic       w_out_valid;
    logic       w_res_valid;
    t_result    w_res;
    t_result    w_out_res;

    // a byte moves on when the result register is free or being drained
    assign w_advance       = r_in_valid && (!w_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_eom  <= i_s_axis_tlast;
        end
    end

    mpk_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_advance),
        .i_byte      (r_in_byte),
        .i_eom       (r_in_eom),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    mpk_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_advance && w_res_valid),
        .i_res   (w_res),
        .i_ready (i_m_axis_tready),
        .o_valid (w_out_valid),
        .o_res   (w_out_res)
    );

    assign o_m_axis_tvalid = w_out_valid;
    assign o_m_axis_tdata  = w_out_res.value;
    assign o_m_axis_tuser  = {w_out_res.err, w_out_res.kind};
    assign o_m_axis_tlast  = w_out_res.done;

endmodule
